>>> hw/rtl/fsd_pkg.sv
// Shared widths, reset values and the stage control type of the error-diffusion dither.
// Used by the channel interfaces, the diffusion datapath and the top level.
`timescale 1ns / 1ps

package fsd_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 11;
    localparam int ERR_W         = 8;
    localparam int CARRY_W       = 7;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_RESET   = 400;

    typedef struct packed {
        logic first_row;
        logic at_left;
        logic has_right;
    } fsd_ctl_t;

endpackage

>>> hw/rtl/fsd_if.sv
// Valid/ready channel interfaces for pixel requests, result bits and the width register.
// Depends on fsd_pkg for the field widths.
`timescale 1ns / 1ps

interface fsd_pixel_if import fsd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface fsd_bit_if ();
    logic valid;
    logic ready;
    logic out_bit;

    modport source (output valid, output out_bit, input ready);
    modport sink (input valid, input out_bit, output ready);
endinterface

interface fsd_cfg_if import fsd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] image_width;

    modport source (output valid, output image_width, input ready);
    modport sink (input valid, input image_width, output ready);
endinterface

>>> hw/rtl/fsd_diffuse.sv
// Diffusion datapath: adds the weighted neighbor errors with clamping and thresholds.
// Depends on fsd_pkg for the widths and the control struct.
`timescale 1ns / 1ps

module fsd_diffuse import fsd_pkg::*;
(
    input  logic [PIX_W-1:0]          pixel_value,
    input  fsd_ctl_t                  ctl,
    input  logic signed [ERR_W-1:0]   above_left,
    input  logic signed [ERR_W-1:0]   above,
    input  logic signed [ERR_W-1:0]   above_right,
    input  logic signed [CARRY_W-1:0] left_carry,
    output logic                      out_bit,
    output logic signed [ERR_W-1:0]   err,
    output logic signed [CARRY_W-1:0] carry_out
);

    localparam int PROD_W = ERR_W + 3;
    localparam int SUM_W  = PIX_W + 2;

    // Signed division by 16 that truncates toward zero.
    function automatic logic signed [CARRY_W-1:0] div16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = (p + (p < 0 ? PROD_W'(signed'(15)) : PROD_W'(signed'(0)))) >>> 4;
        return CARRY_W'(q);
    endfunction

    function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] v,
                                                 input logic signed [CARRY_W-1:0] t);
        logic signed [SUM_W-1:0] s;
        s = $signed({2'b00, v}) + SUM_W'(t);
        if (s < 0)
            return '0;
        else if (s > SUM_W'(signed'(255)))
            return '1;
        else
            return PIX_W'(s);
    endfunction

    logic signed [CARRY_W-1:0] t_above_left;
    logic signed [CARRY_W-1:0] t_above;
    logic signed [CARRY_W-1:0] t_above_right;
    logic [PIX_W-1:0]          v1;
    logic [PIX_W-1:0]          v2;
    logic [PIX_W-1:0]          v3;
    logic [PIX_W-1:0]          v4;
    logic signed [PIX_W:0]     v_ext;

    assign t_above_left  = div16(PROD_W'(above_left));
    assign t_above       = div16(PROD_W'(above) * PROD_W'(signed'(5)));
    assign t_above_right = div16(PROD_W'(above_right) * PROD_W'(signed'(3)));

    assign v1 = (!ctl.first_row && !ctl.at_left) ? sat_add(pixel_value, t_above_left)
                                                 : pixel_value;
    assign v2 = !ctl.first_row ? sat_add(v1, t_above) : v1;
    assign v3 = (!ctl.first_row && ctl.has_right) ? sat_add(v2, t_above_right) : v2;
    assign v4 = !ctl.at_left ? sat_add(v3, left_carry) : v3;

    assign v_ext   = $signed({1'b0, v4});
    assign out_bit = v4[PIX_W-1];
    assign err     = v4[PIX_W-1] ? ERR_W'(v_ext - (PIX_W+1)'(signed'(255))) : ERR_W'(v_ext);
    assign carry_out = div16(PROD_W'(err) * PROD_W'(signed'(7)));

endmodule

>>> hw/rtl/floyd_steinberg_dither_core.sv
// Top level of the streaming error-diffusion dither with its line store of row errors.
// Depends on fsd_pkg, the channel interfaces in fsd_if and the fsd_diffuse datapath.
`timescale 1ns / 1ps

// Grey pixels enter on the pixels channel in raster order, one request per pixel; a set
// frame_start marks the first pixel of an image. Each pixel yields one bit on the bits
// channel, 1 for white. The cfg channel writes the row width and is always ready; the
// user must write it only while no pixel is in flight, which the block does not enforce.
// An accepted pixel passes the store read stage, then the output register. The block
// takes one pixel per clock while the receiver does not stall. On acceptance the line
// store is read at the pixel's column and the next one; then the datapath adds the
// diffused errors and writes the new error back; a write to the entry read in the same
// cycle is forwarded. When the receiver stalls, the output register holds its bit, one
// more pixel waits in the store read stage, and then ready falls.
// Reset empties the pipeline, sets the width to 400 (at most MAX_WIDTH) and starts at the
// first row. The line store is not cleared; first-row pixels ignore it.
module floyd_steinberg_dither_core import fsd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    fsd_pixel_if.sink     pixels,
    fsd_bit_if.source     bits,
    fsd_cfg_if.sink       cfg
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam logic [CNT_W-1:0] WIDTH_MAX = CNT_W'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] WIDTH_RST =
        CNT_W'((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET);

    logic signed [ERR_W-1:0] err_mem [MAX_WIDTH];

    logic [CNT_W-1:0]  width_reg;
    logic [ADDR_W-1:0] col_reg;
    logic              first_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;

    logic [PIX_W-1:0]          s1_pix_reg;
    fsd_ctl_t                  s1_ctl_reg;
    logic [ADDR_W-1:0]         s1_x_reg;
    logic                      fwd0_reg;
    logic                      fwd1_reg;
    logic signed [ERR_W-1:0]   fwd_data_reg;
    logic signed [ERR_W-1:0]   q0_reg;
    logic signed [ERR_W-1:0]   q1_reg;
    logic signed [ERR_W-1:0]   above_left_reg;
    logic signed [CARRY_W-1:0] carry_reg;
    logic                      out_bit_reg;

    logic [CNT_W-1:0]          width_next;
    logic [ADDR_W-1:0]         col_pre;
    logic                      first_pre;
    logic [ADDR_W-1:0]         col_x;
    logic                      first_x;
    logic [CNT_W-1:0]          x_plus1;
    logic                      has_right;
    logic [ADDR_W-1:0]         rd_addr1;
    logic                      accept;
    logic                      s1_adv;
    logic                      wr_en;
    fsd_ctl_t                  ctl_next;
    logic signed [ERR_W-1:0]   above;
    logic signed [ERR_W-1:0]   above_right;
    logic signed [ERR_W-1:0]   above_left;
    logic                      bit_c;
    logic signed [ERR_W-1:0]   err_c;
    logic signed [CARRY_W-1:0] carry_c;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (cfg.image_width == '0)
            width_next = CNT_W'(1);
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
            width_next = WIDTH_MAX;
        else
            width_next = CNT_W'(cfg.image_width);
    end

    always_comb
    begin
        col_pre   = pixels.frame_start ? '0 : col_reg;
        first_pre = pixels.frame_start | first_reg;
        if ({1'b0, col_pre} >= width_reg)
        begin
            col_x   = '0;
            first_x = 1'b0;
        end
        else
        begin
            col_x   = col_pre;
            first_x = first_pre;
        end
        x_plus1   = {1'b0, col_x} + CNT_W'(1);
        has_right = x_plus1 < width_reg;
        rd_addr1  = has_right ? x_plus1[ADDR_W-1:0] : col_x;
        ctl_next.first_row = first_x;
        ctl_next.at_left   = (col_x == '0);
        ctl_next.has_right = has_right;
    end

    assign s1_adv       = !out_valid_reg || bits.ready;
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign accept       = pixels.valid && pixels.ready;
    assign wr_en        = s1_valid_reg && s1_adv;

    assign above       = fwd0_reg ? fwd_data_reg : q0_reg;
    assign above_right = fwd1_reg ? fwd_data_reg : q1_reg;
    assign above_left  = s1_ctl_reg.at_left ? '0 : above_left_reg;

    fsd_diffuse u_diffuse (
        .pixel_value (s1_pix_reg),
        .ctl         (s1_ctl_reg),
        .above_left  (above_left),
        .above       (above),
        .above_right (above_right),
        .left_carry  (carry_reg),
        .out_bit     (bit_c),
        .err         (err_c),
        .carry_out   (carry_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RST;
            col_reg       <= '0;
            first_reg     <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                width_reg <= width_next;
            if (accept)
            begin
                col_reg   <= has_right ? x_plus1[ADDR_W-1:0] : '0;
                first_reg <= has_right ? first_x : 1'b0;
            end
            if (pixels.ready)
                s1_valid_reg <= pixels.valid;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixels.pixel_value;
            s1_ctl_reg   <= ctl_next;
            s1_x_reg     <= col_x;
            fwd0_reg     <= wr_en && (s1_x_reg == col_x);
            fwd1_reg     <= wr_en && (s1_x_reg == rd_addr1);
            fwd_data_reg <= err_c;
        end
        if (wr_en)
        begin
            out_bit_reg    <= bit_c;
            above_left_reg <= above;
            carry_reg      <= carry_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            err_mem[s1_x_reg] <= err_c;
        if (accept)
        begin
            q0_reg <= err_mem[col_x];
            q1_reg <= err_mem[rd_addr1];
        end
    end

    assign bits.valid   = out_valid_reg;
    assign bits.out_bit = out_bit_reg;

endmodule

>>> hw/rtl/fsd_checker.sv
// Port-level checks on the dither core's pixel and bit channels.
// Attached to floyd_steinberg_dither_core by the bind statement at the end of this file.
`timescale 1ns / 1ps

module fsd_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_bit
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bit))
    else $error("Result bit changed or vanished while the receiver stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("Pixel channel not ready although the result side can move.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("Result appeared without a pixel request two cycles earlier.");

endmodule

bind floyd_steinberg_dither_core fsd_checker u_fsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (bits.valid),
    .out_ready (bits.ready),
    .out_bit   (bits.out_bit)
);
